// ===== hw/rtl/push_button_dimmer_control_assert.svh =====
// Assertion macros for the push-button dimmer control block.
`ifndef PUSH_BUTTON_DIMMER_CONTROL_ASSERT_SVH
`define PUSH_BUTTON_DIMMER_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBDC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pbdc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pbdc: next-cycle check failed");

`endif

// ===== hw/rtl/pbdc_pkg.sv =====
// Shared types, constants and register map of the push-button dimmer control block.
package pbdc_pkg;

    localparam int unsigned CHANNELS_DEF  = 8;
    localparam int unsigned MAX_LEVEL_DEF = 127;

    localparam int unsigned CHANNEL_W = 3;
    localparam int unsigned NOW_W     = 8;
    localparam int unsigned LAMP_W    = 7;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_CHANNEL_ENABLE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_TIME       = 2'd2;

    localparam logic [CFG_W-1:0] ENABLE_RESET = 8'd0;
    localparam logic [CFG_W-1:0] REPEAT_RESET = 8'd10;
    localparam logic [CFG_W-1:0] HOLD_RESET   = 8'd200;

    typedef struct packed {
        logic ramp_up;
        logic was_pressed;
        logic ramping;
    } pbdc_flags_t;

endpackage

// ===== hw/rtl/pbdc_step.sv =====
// Per-poll update of one channel: press timing, ramp step and short-press toggle.
module pbdc_step #(
    parameter int unsigned MAX_LEVEL = pbdc_pkg::MAX_LEVEL_DEF,
    parameter int unsigned LEVEL_W   = $clog2(MAX_LEVEL + 1)
) (
    input  logic                          enabled,
    input  logic                          pressed,
    input  logic [pbdc_pkg::NOW_W-1:0]    now,
    input  logic [pbdc_pkg::CFG_W-1:0]    repeat_interval,
    input  logic [pbdc_pkg::CFG_W-1:0]    hold_time,
    input  logic [pbdc_pkg::NOW_W-1:0]    last_step_time,
    input  logic [LEVEL_W-1:0]            level_cur,
    input  logic [pbdc_pkg::NOW_W-1:0]    release_cur,
    input  pbdc_pkg::pbdc_flags_t         flags_cur,
    output logic [LEVEL_W-1:0]            level_nxt,
    output logic [pbdc_pkg::NOW_W-1:0]    release_nxt,
    output pbdc_pkg::pbdc_flags_t         flags_nxt,
    output logic [pbdc_pkg::NOW_W-1:0]    last_step_nxt,
    output logic                          changed
);

    localparam logic [LEVEL_W-1:0] MAX_L = LEVEL_W'(MAX_LEVEL);

    logic [pbdc_pkg::NOW_W-1:0] since_step;
    logic [pbdc_pkg::NOW_W-1:0] since_release;
    logic                       held;
    logic                       dir_up;
    logic [LEVEL_W-1:0]         stepped;

    assign since_step    = now - last_step_time;
    assign since_release = now - release_cur;
    assign held          = since_release > hold_time;

    // reverse at an end before stepping, so the level never wraps
    always_comb begin
        dir_up = flags_cur.ramp_up;
        if (flags_cur.ramp_up && level_cur >= MAX_L) begin
            dir_up = 1'b0;
        end else if (!flags_cur.ramp_up && level_cur == '0) begin
            dir_up = 1'b1;
        end
        stepped = dir_up ? level_cur + 1'b1 : level_cur - 1'b1;
    end

    always_comb begin
        level_nxt     = level_cur;
        release_nxt   = release_cur;
        flags_nxt     = flags_cur;
        last_step_nxt = last_step_time;
        changed       = 1'b0;
        if (pressed) begin
            flags_nxt.was_pressed = 1'b1;
            if (since_step > repeat_interval) begin
                if ((held || flags_cur.ramping) && enabled) begin
                    flags_nxt.ramping = 1'b1;
                    level_nxt         = stepped;
                    flags_nxt.ramp_up = dir_up ? (stepped < MAX_L) : (stepped == '0);
                    changed           = 1'b1;
                end
                last_step_nxt = now;
            end
        end else begin
            if (flags_cur.was_pressed) begin
                flags_nxt.was_pressed = 1'b0;
                if (flags_cur.ramping) begin
                    flags_nxt.ramping = 1'b0;
                    flags_nxt.ramp_up = !flags_cur.ramp_up;
                end else if (level_cur == '0) begin
                    level_nxt         = MAX_L;
                    flags_nxt.ramp_up = 1'b0;
                    changed           = 1'b1;
                end else begin
                    level_nxt         = '0;
                    flags_nxt.ramp_up = 1'b1;
                    changed           = 1'b1;
                end
            end
            release_nxt = now;
        end
    end

endmodule

// ===== hw/rtl/push_button_dimmer_control.sv =====
// Top level of the push-button dimmer control block: handshake, state and config registers.
//
//   channel   direction  ports
//   s_        in         s_valid s_ready s_channel s_pressed s_now
//   m_        out        m_valid m_ready m_lamp_level m_changed
//   apb       in/out     psel penable pwrite paddr pwdata prdata pready
//
// One word per cycle sustained while m_ready stays high; a word passes the input register, then the result register.
// The per-channel state is updated in the same cycle as the result register is loaded,
// so the next word always sees the updated state.
// A stalled result register holds the word in the input register; s_ready drops only then.
// Reset clears channel levels, release and step times, sets each ramp direction to up and loads the register defaults.
module push_button_dimmer_control #(
    parameter int unsigned CHANNELS  = pbdc_pkg::CHANNELS_DEF,
    parameter int unsigned MAX_LEVEL = pbdc_pkg::MAX_LEVEL_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pbdc_pkg::CHANNEL_W-1:0]    s_channel,
    input  logic                              s_pressed,
    input  logic [pbdc_pkg::NOW_W-1:0]        s_now,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pbdc_pkg::LAMP_W-1:0]       m_lamp_level,
    output logic                              m_changed,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbdc_pkg::ADDR_W-1:0]       paddr,
    input  logic [pbdc_pkg::DATA_W-1:0]       pwdata,
    output logic [pbdc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    `include "push_button_dimmer_control_assert.svh"

    localparam int unsigned LEVEL_W = $clog2(MAX_LEVEL + 1);
    localparam int unsigned LAMP_W  = pbdc_pkg::LAMP_W;

    // config registers
    logic [pbdc_pkg::CFG_W-1:0] enable_reg;
    logic [pbdc_pkg::CFG_W-1:0] repeat_reg;
    logic [pbdc_pkg::CFG_W-1:0] hold_reg;
    logic [pbdc_pkg::IDX_W-1:0] reg_idx;
    logic                       cfg_write;

    // input stage
    logic                           in_valid_reg;
    logic [pbdc_pkg::CHANNEL_W-1:0] in_channel_reg;
    logic                           in_pressed_reg;
    logic [pbdc_pkg::NOW_W-1:0]     in_now_reg;

    // result stage
    logic                    m_valid_reg;
    logic [LAMP_W-1:0]       m_lamp_level_reg;
    logic                    m_changed_reg;
    logic [LAMP_W-1:0]       m_lamp_level_next;
    logic                    m_changed_next;

    // channel state
    logic [LEVEL_W-1:0]             level_reg   [CHANNELS];
    logic [pbdc_pkg::NOW_W-1:0]     release_reg [CHANNELS];
    pbdc_pkg::pbdc_flags_t          flags_reg   [CHANNELS];
    logic [pbdc_pkg::NOW_W-1:0]     last_step_reg;

    logic                           advance;
    logic                           in_range;
    logic [LEVEL_W-1:0]             level_cur;
    logic [pbdc_pkg::NOW_W-1:0]     release_cur;
    pbdc_pkg::pbdc_flags_t          flags_cur;
    logic [LEVEL_W-1:0]             level_nxt;
    logic [pbdc_pkg::NOW_W-1:0]     release_nxt;
    pbdc_pkg::pbdc_flags_t          flags_nxt;
    logic [pbdc_pkg::NOW_W-1:0]     last_step_nxt;
    logic                           step_changed;
    logic [LEVEL_W+LAMP_W-1:0]      level_ext;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[pbdc_pkg::ADDR_W-1:pbdc_pkg::ADDR_W-pbdc_pkg::IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            pbdc_pkg::REG_CHANNEL_ENABLE:  prdata = pbdc_pkg::DATA_W'(enable_reg);
            pbdc_pkg::REG_REPEAT_INTERVAL: prdata = pbdc_pkg::DATA_W'(repeat_reg);
            pbdc_pkg::REG_HOLD_TIME:       prdata = pbdc_pkg::DATA_W'(hold_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= pbdc_pkg::ENABLE_RESET;
            repeat_reg <= pbdc_pkg::REPEAT_RESET;
            hold_reg   <= pbdc_pkg::HOLD_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                pbdc_pkg::REG_CHANNEL_ENABLE:  enable_reg <= pwdata[pbdc_pkg::CFG_W-1:0];
                pbdc_pkg::REG_REPEAT_INTERVAL: repeat_reg <= pwdata[pbdc_pkg::CFG_W-1:0];
                pbdc_pkg::REG_HOLD_TIME:       hold_reg   <= pwdata[pbdc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_channel_reg <= s_channel;
            in_pressed_reg <= s_pressed;
            in_now_reg     <= s_now;
        end
    end

    // ---------------- channel state read ----------------
    assign in_range = 32'(in_channel_reg) < CHANNELS;

    always_comb begin
        level_cur   = '0;
        release_cur = '0;
        flags_cur   = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (32'(in_channel_reg) == i) begin
                level_cur   = level_reg[i];
                release_cur = release_reg[i];
                flags_cur   = flags_reg[i];
            end
        end
    end

    pbdc_step #(
        .MAX_LEVEL (MAX_LEVEL),
        .LEVEL_W   (LEVEL_W)
    ) u_step (
        .enabled         (enable_reg[in_channel_reg]),
        .pressed         (in_pressed_reg),
        .now             (in_now_reg),
        .repeat_interval (repeat_reg),
        .hold_time       (hold_reg),
        .last_step_time  (last_step_reg),
        .level_cur       (level_cur),
        .release_cur     (release_cur),
        .flags_cur       (flags_cur),
        .level_nxt       (level_nxt),
        .release_nxt     (release_nxt),
        .flags_nxt       (flags_nxt),
        .last_step_nxt   (last_step_nxt),
        .changed         (step_changed)
    );

    // ---------------- channel state write ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i]   <= '0;
                release_reg[i] <= '0;
                flags_reg[i]   <= '{ramp_up: 1'b1, was_pressed: 1'b0, ramping: 1'b0};
            end
            last_step_reg <= '0;
        end else if (advance && in_range) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (32'(in_channel_reg) == i) begin
                    level_reg[i]   <= level_nxt;
                    release_reg[i] <= release_nxt;
                    flags_reg[i]   <= flags_nxt;
                end
            end
            last_step_reg <= last_step_nxt;
        end
    end

    // ---------------- result register ----------------
    assign level_ext = {LAMP_W'(0), level_nxt};

    always_comb begin
        m_lamp_level_next = '0;
        m_changed_next    = 1'b0;
        if (in_range) begin
            m_lamp_level_next = level_ext[LAMP_W-1:0];
            m_changed_next    = step_changed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_lamp_level_reg <= m_lamp_level_next;
            m_changed_reg    <= m_changed_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_lamp_level = m_lamp_level_reg;
    assign m_changed    = m_changed_reg;

    // ---------------- assertions ----------------
    `PBDC_ASSERT_NOW(a_level_bound, aclk, aresetn, advance && in_range, level_nxt <= LEVEL_W'(MAX_LEVEL))
    `PBDC_ASSERT_NEXT(a_ignored_zero, aclk, aresetn, advance && !in_range, m_valid && m_lamp_level == '0 && !m_changed)
    `PBDC_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && m_valid_reg && !m_ready)

endmodule
